>>> hw/rtl/haar_feature_enumerator_assert.svh
// Assertion macros for the Haar feature enumerator, clocked on clk_i and reset by rst_ni
`ifndef HAAR_FEATURE_ENUMERATOR_ASSERT_SVH
`define HAAR_FEATURE_ENUMERATOR_ASSERT_SVH

`ifndef ASSERT_OFF

// Same-cycle implication
`define HFE_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define HFE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`else

`define HFE_ASSERT_IMPLY(lbl, ante, cons, msg)
`define HFE_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

>>> hw/rtl/hfe_pkg.sv
// Shared types, constants and helper functions of the Haar feature enumerator
`timescale 1ns / 1ps

package hfe_pkg;

  // Window geometry
  localparam int unsigned MaxWindow = 64;
  localparam int unsigned CoordW    = $clog2(MaxWindow);
  localparam int unsigned DimW      = CoordW + 1;
  localparam int unsigned NumFam    = 5;
  localparam int unsigned KeepW     = 4;

  typedef logic [DimW-1:0]   dim_t;
  typedef logic [CoordW-1:0] coord_t;

  // Keep one candidate in ten, at count five
  localparam logic [KeepW-1:0] KeepHit  = KeepW'(5);
  localparam logic [KeepW-1:0] KeepLast = KeepW'(9);

  // Feature families; FamNone marks the end of the walk
  typedef enum logic [2:0] {
    FamH2   = 3'd0,
    FamV2   = 3'd1,
    FamH3   = 3'd2,
    FamV3   = 3'd3,
    FamQuad = 3'd4,
    FamNone = 3'd5
  } fam_e;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CfgWinW  = 3'd0,
    CfgWinH  = 3'd1,
    CfgMinW  = 3'd2,
    CfgMinH  = 3'd3,
    CfgMaxW  = 3'd4,
    CfgMaxH  = 3'd5,
    CfgFamEn = 3'd6
  } cfg_idx_e;

  // Reset values of the configuration registers
  localparam dim_t       WinWRst  = dim_t'(24);
  localparam dim_t       WinHRst  = dim_t'(24);
  localparam dim_t       MinWRst  = dim_t'(1);
  localparam dim_t       MinHRst  = dim_t'(1);
  localparam dim_t       MaxWRst  = dim_t'(24);
  localparam dim_t       MaxHRst  = dim_t'(24);
  localparam logic [2:0] FamEnRst = 3'b111;

  // Rectangle weights
  localparam logic signed [1:0] WZero = 2'sb00;
  localparam logic signed [1:0] WPos  = 2'sb01;
  localparam logic signed [1:0] WNeg  = 2'sb11;
  localparam logic signed [1:0] WDbl  = 2'sb10;

  typedef enum logic [2:0] {
    SIdle,
    SInit,
    SSeek,
    SPrep,
    SEmit
  } state_e;

  // Live limits derived from the configuration registers
  typedef struct packed {
    dim_t            ww;
    dim_t            wh;
    dim_t            mw;
    dim_t            mh;
    logic [2:0][DimW-1:0] rmw;  // rounded min width for steps 1, 2, 3
    logic [2:0][DimW-1:0] rmh;  // rounded min height for steps 1, 2, 3
    logic [2:0]      fam_en;
  } lim_t;

  // Controller to datapath
  typedef struct packed {
    logic restart;
    logic step;
    logic prep;
    logic emit_rect;
    logic emit_mark;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic finished;
    logic cand;
    logic kept;
    logic slot_free;
    logic rect_last;
  } sts_t;

  // One result item
  typedef struct packed {
    logic [2:0]        family;
    coord_t            left;
    coord_t            top;
    coord_t            right;
    coord_t            bottom;
    logic signed [1:0] weight;
    logic              last_rect;
    logic              exhausted;
  } out_t;

  function automatic logic [1:0] step_w(fam_e f);
    case (f)
      FamH2:   return 2'd2;
      FamV2:   return 2'd1;
      FamH3:   return 2'd3;
      FamV3:   return 2'd1;
      FamQuad: return 2'd2;
      default: return 2'd1;
    endcase
  endfunction

  function automatic logic [1:0] step_h(fam_e f);
    case (f)
      FamH2:   return 2'd1;
      FamV2:   return 2'd2;
      FamH3:   return 2'd1;
      FamV3:   return 2'd3;
      FamQuad: return 2'd2;
      default: return 2'd1;
    endcase
  endfunction

  function automatic logic fam_on(fam_e f, logic [2:0] en);
    case (f)
      FamH2, FamV2: return en[0];
      FamH3, FamV3: return en[1];
      FamQuad:      return en[2];
      default:      return 1'b0;
    endcase
  endfunction

  // First enabled family at or after from
  function automatic fam_e next_family(logic [2:0] from, logic [2:0] en);
    fam_e res;
    logic found;
    res   = FamNone;
    found = 1'b0;
    for (int i = 0; i < NumFam; i++) begin
      if (!found && (3'(i) >= from) && fam_on(fam_e'(3'(i)), en)) begin
        res   = fam_e'(3'(i));
        found = 1'b1;
      end
    end
    return res;
  endfunction

  // Divide by three: reciprocal multiply with one correction, exact below 128
  function automatic dim_t div3(dim_t v);
    logic [DimW+7:0] prod;
    dim_t q;
    dim_t r;
    prod = (DimW+8)'(v) * (DimW+8)'(171);
    q    = dim_t'(prod >> 9);
    r    = v - dim_t'({q, 1'b0}) - q;
    if (r >= dim_t'(3)) begin
      q = q + dim_t'(1);
    end
    return q;
  endfunction

  // Round down to the step, raise zero to the step
  function automatic dim_t round_min(dim_t v, logic [1:0] step);
    dim_t r;
    case (step)
      2'd2:    r = {v[DimW-1:1], 1'b0};
      2'd3:    r = dim_t'({div3(v), 1'b0}) + div3(v);
      default: r = v;
    endcase
    if (r == '0) begin
      r = dim_t'(step);
    end
    return r;
  endfunction

  function automatic dim_t lim_min(dim_t a, dim_t b);
    return (a > b) ? b : a;
  endfunction

  // Build the limit set from raw register values
  function automatic lim_t make_lim(dim_t win_w, dim_t win_h, dim_t min_w, dim_t min_h,
                                    dim_t max_w, dim_t max_h, logic [2:0] en);
    lim_t l;
    l.ww     = lim_min(win_w, dim_t'(MaxWindow));
    l.wh     = lim_min(win_h, dim_t'(MaxWindow));
    l.mw     = lim_min(max_w, l.ww);
    l.mh     = lim_min(max_h, l.wh);
    l.rmw[0] = round_min(min_w, 2'd1);
    l.rmw[1] = round_min(min_w, 2'd2);
    l.rmw[2] = round_min(min_w, 2'd3);
    l.rmh[0] = round_min(min_h, 2'd1);
    l.rmh[1] = round_min(min_h, 2'd2);
    l.rmh[2] = round_min(min_h, 2'd3);
    l.fam_en = en;
    return l;
  endfunction

endpackage

>>> hw/rtl/hfe_ctrl.sv
// Controller state machine: request handshake, candidate walk and rectangle emission
`timescale 1ns / 1ps

module hfe_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          req_valid_i,
  input  logic          req_restart_i,
  output logic          req_ready_o,
  input  hfe_pkg::sts_t sts_i,
  output hfe_pkg::cmd_t cmd_o
);

  hfe_pkg::state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= hfe_pkg::SIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d     = state_q;
    req_ready_o = 1'b0;
    cmd_o       = '0;
    case (state_q)
      hfe_pkg::SIdle: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          state_d = req_restart_i ? hfe_pkg::SInit : hfe_pkg::SSeek;
        end
      end
      hfe_pkg::SInit: begin
        cmd_o.restart = 1'b1;
        state_d       = hfe_pkg::SSeek;
      end
      hfe_pkg::SSeek: begin
        if (sts_i.finished) begin
          // Walk over: send the exhausted marker once the slot is free
          if (sts_i.slot_free) begin
            cmd_o.emit_mark = 1'b1;
            state_d         = hfe_pkg::SIdle;
          end
        end else begin
          cmd_o.step = 1'b1;
          if (sts_i.cand && sts_i.kept) begin
            state_d = hfe_pkg::SPrep;
          end
        end
      end
      hfe_pkg::SPrep: begin
        cmd_o.prep = 1'b1;
        state_d    = hfe_pkg::SEmit;
      end
      hfe_pkg::SEmit: begin
        if (sts_i.slot_free) begin
          cmd_o.emit_rect = 1'b1;
          if (sts_i.rect_last) begin
            state_d = hfe_pkg::SIdle;
          end
        end
      end
      default: begin
        state_d = hfe_pkg::SIdle;
      end
    endcase
  end

endmodule

>>> hw/rtl/hfe_dp.sv
// Datapath: walk cursor, kept-feature register, rectangle builder and output register
`timescale 1ns / 1ps

module hfe_dp (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  hfe_pkg::lim_t lim_i,
  input  hfe_pkg::cmd_t cmd_i,
  output hfe_pkg::sts_t sts_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output hfe_pkg::out_t out_data_o
);

  // Cursor state
  hfe_pkg::fam_e              fam_q, fam_d;
  hfe_pkg::dim_t              px_q, px_d, py_q, py_d;
  hfe_pkg::dim_t              cw_q, cw_d, ch_q, ch_d;
  logic [hfe_pkg::KeepW-1:0]  keep_q, keep_d;
  logic                       fin_q, fin_d;

  // Kept feature
  hfe_pkg::fam_e   ffam_q;
  hfe_pkg::coord_t fx_q, fy_q;
  hfe_pkg::dim_t   fw_q, fh_q, fw3_q, fh3_q;
  logic [1:0]      ridx_q;

  // Output register
  logic          ovld_q;
  hfe_pkg::out_t odata_q, rect, mark;

  // Walk helpers
  logic [1:0]    sw, sh;
  hfe_pkg::dim_t rw, rh;
  logic [2:0]    from;
  hfe_pkg::fam_e sfam;
  logic          s_none;
  hfe_pkg::dim_t s_w, s_h;
  logic [hfe_pkg::DimW:0] sum_x, sum_y;
  logic          x_end, y_end, x_out, y_out, cand, kept, slot_free, rect_last;

  // Rectangle arithmetic
  logic [hfe_pkg::DimW:0] x8, y8, w8, h8, w2, h2, w3, h3;
  logic [hfe_pkg::DimW:0] l8, t8, r8, b8;
  logic signed [1:0]      wgt;

  assign sw = hfe_pkg::step_w(fam_q);
  assign sh = hfe_pkg::step_h(fam_q);
  assign rw = lim_i.rmw[sw - 2'd1];
  assign rh = lim_i.rmh[sh - 2'd1];

  // Start of a family: from the first one on restart, else after the current one
  assign from   = cmd_i.restart ? 3'd0 : (3'(fam_q) + 3'd1);
  assign sfam   = hfe_pkg::next_family(from, lim_i.fam_en);
  assign s_none = (sfam == hfe_pkg::FamNone);
  assign s_w    = s_none ? '0 : lim_i.rmw[hfe_pkg::step_w(sfam) - 2'd1];
  assign s_h    = s_none ? '0 : lim_i.rmh[hfe_pkg::step_h(sfam) - 2'd1];

  // Loop bounds of the current cursor
  assign sum_x = {1'b0, px_q} + {1'b0, cw_q};
  assign sum_y = {1'b0, py_q} + {1'b0, ch_q};
  assign x_out = (px_q >= lim_i.ww);
  assign y_out = (py_q >= lim_i.wh);
  assign x_end = (sum_x > {1'b0, lim_i.mw});
  assign y_end = (sum_y > {1'b0, lim_i.mh});
  assign cand  = !fin_q && (fam_q != hfe_pkg::FamNone) && !x_out && !y_out &&
                 !x_end && !y_end;
  assign kept  = (keep_q == hfe_pkg::KeepHit);

  assign slot_free = !ovld_q || out_ready_i;
  assign rect_last = (ffam_q == hfe_pkg::FamQuad) ? (ridx_q == 2'd2) : (ridx_q == 2'd1);

  assign sts_o.finished  = fin_q;
  assign sts_o.cand      = cand;
  assign sts_o.kept      = kept;
  assign sts_o.slot_free = slot_free;
  assign sts_o.rect_last = rect_last;

  // One walk step per cycle while the controller commands a step and the walk is not finished
  always_comb begin
    fam_d  = fam_q;
    px_d   = px_q;
    py_d   = py_q;
    cw_d   = cw_q;
    ch_d   = ch_q;
    keep_d = keep_q;
    fin_d  = fin_q;
    if (cmd_i.restart) begin
      keep_d = '0;
      fin_d  = s_none;
      fam_d  = sfam;
      px_d   = '0;
      py_d   = '0;
      cw_d   = s_w;
      ch_d   = s_h;
    end else if (cmd_i.step && !fin_q) begin
      if (fam_q == hfe_pkg::FamNone) begin
        fin_d = 1'b1;
      end else if (x_out) begin
        // Family done: move to the next enabled one
        fin_d = s_none;
        fam_d = sfam;
        px_d  = '0;
        py_d  = '0;
        cw_d  = s_w;
        ch_d  = s_h;
      end else if (y_out) begin
        px_d = px_q + hfe_pkg::dim_t'(1);
        py_d = '0;
        cw_d = rw;
        ch_d = rh;
      end else if (x_end) begin
        py_d = py_q + hfe_pkg::dim_t'(1);
        cw_d = rw;
        ch_d = rh;
      end else if (y_end) begin
        cw_d = cw_q + hfe_pkg::dim_t'(sw);
        ch_d = rh;
      end else begin
        // Candidate: count it and advance the height
        keep_d = (keep_q == hfe_pkg::KeepLast) ? '0 : keep_q + 1'b1;
        ch_d   = ch_q + hfe_pkg::dim_t'(sh);
      end
    end
  end

  // Cursor registers, reset to the first candidate of the default setup
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fam_q  <= hfe_pkg::next_family(3'd0, hfe_pkg::FamEnRst);
      px_q   <= '0;
      py_q   <= '0;
      cw_q   <= hfe_pkg::round_min(hfe_pkg::MinWRst,
                  hfe_pkg::step_w(hfe_pkg::next_family(3'd0, hfe_pkg::FamEnRst)));
      ch_q   <= hfe_pkg::round_min(hfe_pkg::MinHRst,
                  hfe_pkg::step_h(hfe_pkg::next_family(3'd0, hfe_pkg::FamEnRst)));
      keep_q <= '0;
      fin_q  <= 1'b0;
    end else begin
      fam_q  <= fam_d;
      px_q   <= px_d;
      py_q   <= py_d;
      cw_q   <= cw_d;
      ch_q   <= ch_d;
      keep_q <= keep_d;
      fin_q  <= fin_d;
    end
  end

  // Capture the kept feature, then its thirds
  always_ff @(posedge clk_i) begin
    if (cmd_i.step && cand && kept) begin
      ffam_q <= fam_q;
      fx_q   <= px_q[hfe_pkg::CoordW-1:0];
      fy_q   <= py_q[hfe_pkg::CoordW-1:0];
      fw_q   <= cw_q;
      fh_q   <= ch_q;
    end
    if (cmd_i.prep) begin
      fw3_q <= hfe_pkg::div3(fw_q);
      fh3_q <= hfe_pkg::div3(fh_q);
    end
  end

  // Rectangle index within the feature
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ridx_q <= '0;
    end else if (cmd_i.prep) begin
      ridx_q <= '0;
    end else if (cmd_i.emit_rect) begin
      ridx_q <= ridx_q + 2'd1;
    end
  end

  // Corners of the current rectangle
  assign x8 = {2'b00, fx_q};
  assign y8 = {2'b00, fy_q};
  assign w8 = {1'b0, fw_q};
  assign h8 = {1'b0, fh_q};
  assign w2 = w8 >> 1;
  assign h2 = h8 >> 1;
  assign w3 = {1'b0, fw3_q};
  assign h3 = {1'b0, fh3_q};

  always_comb begin
    // Whole box with positive weight by default
    l8  = x8;
    t8  = y8;
    r8  = x8 + w8 - 1'b1;
    b8  = y8 + h8 - 1'b1;
    wgt = hfe_pkg::WPos;
    case (ffam_q)
      hfe_pkg::FamH2: begin
        if (ridx_q == 2'd0) begin
          r8 = x8 + w2 - 1'b1;
        end else begin
          l8  = x8 + w2;
          wgt = hfe_pkg::WNeg;
        end
      end
      hfe_pkg::FamV2: begin
        if (ridx_q == 2'd0) begin
          b8 = y8 + h2 - 1'b1;
        end else begin
          t8  = y8 + h2;
          wgt = hfe_pkg::WNeg;
        end
      end
      hfe_pkg::FamH3: begin
        if (ridx_q != 2'd0) begin
          l8  = x8 + w3;
          r8  = x8 + {w3[hfe_pkg::DimW-1:0], 1'b0} - 1'b1;
          wgt = hfe_pkg::WDbl;
        end
      end
      hfe_pkg::FamV3: begin
        if (ridx_q != 2'd0) begin
          t8  = y8 + h3;
          b8  = y8 + {h3[hfe_pkg::DimW-1:0], 1'b0} - 1'b1;
          wgt = hfe_pkg::WDbl;
        end
      end
      default: begin
        // Four-rect: top-right then bottom-left quarter
        if (ridx_q == 2'd1) begin
          l8  = x8 + w2;
          b8  = y8 + h2 - 1'b1;
          wgt = hfe_pkg::WDbl;
        end else if (ridx_q == 2'd2) begin
          t8  = y8 + h2;
          r8  = x8 + w2 - 1'b1;
          wgt = hfe_pkg::WDbl;
        end
      end
    endcase
    rect.family    = 3'(ffam_q);
    rect.left      = l8[hfe_pkg::CoordW-1:0];
    rect.top       = t8[hfe_pkg::CoordW-1:0];
    rect.right     = r8[hfe_pkg::CoordW-1:0];
    rect.bottom    = b8[hfe_pkg::CoordW-1:0];
    rect.weight    = wgt;
    rect.last_rect = rect_last;
    rect.exhausted = 1'b0;
  end

  // Exhausted marker: zero coordinates and weight, last and exhausted set
  always_comb begin
    mark           = '0;
    mark.weight    = hfe_pkg::WZero;
    mark.last_rect = 1'b1;
    mark.exhausted = 1'b1;
  end

  // Output register: load a rectangle or the marker, drop on transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovld_q <= 1'b0;
    end else if (cmd_i.emit_rect || cmd_i.emit_mark) begin
      ovld_q <= 1'b1;
    end else if (out_ready_i) begin
      ovld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_mark) begin
      odata_q <= mark;
    end else if (cmd_i.emit_rect) begin
      odata_q <= rect;
    end
  end

  assign out_valid_o = ovld_q;
  assign out_data_o  = odata_q;

endmodule

>>> hw/rtl/haar_feature_enumerator.sv
// Flow: a request is taken in SIdle, passes through SInit on restart, then SSeek walks the
// candidates and loop boundaries, SPrep prepares the kept feature and SEmit sends its rectangles.
// Only one request is in flight; a running walk covers ten candidates per kept feature,
// plus the loop boundaries crossed, and SEmit waits for a free output slot.
// When the walk is over, SSeek loads the exhausted marker once the output slot is free.
// Reset (asynchronous, active low) restores the default configuration and the first candidate.
`timescale 1ns / 1ps

`include "haar_feature_enumerator_assert.svh"

module haar_feature_enumerator (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration write port
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [6:0]  cfg_wdata_i,
  // Request stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [0] restart, [7:1] zero
  // Result stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // [2:0] family, [8:3] rect_left, [14:9] rect_top,
                                        // [20:15] rect_right, [26:21] rect_bottom,
                                        // [28:27] weight, [31:29] zero
  output logic        m_axis_tlast_o,   // last_rect
  output logic        m_axis_tuser_o    // exhausted
);

  hfe_pkg::dim_t win_w_q, win_h_q, min_w_q, min_h_q, max_w_q, max_h_q;
  logic [2:0]    fam_en_q;
  hfe_pkg::lim_t lim_q;
  hfe_pkg::cmd_t cmd;
  hfe_pkg::sts_t sts;
  hfe_pkg::out_t odata;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_w_q  <= hfe_pkg::WinWRst;
      win_h_q  <= hfe_pkg::WinHRst;
      min_w_q  <= hfe_pkg::MinWRst;
      min_h_q  <= hfe_pkg::MinHRst;
      max_w_q  <= hfe_pkg::MaxWRst;
      max_h_q  <= hfe_pkg::MaxHRst;
      fam_en_q <= hfe_pkg::FamEnRst;
    end else if (cfg_we_i) begin
      case (hfe_pkg::cfg_idx_e'(cfg_idx_i))
        hfe_pkg::CfgWinW:  win_w_q  <= cfg_wdata_i;
        hfe_pkg::CfgWinH:  win_h_q  <= cfg_wdata_i;
        hfe_pkg::CfgMinW:  min_w_q  <= cfg_wdata_i;
        hfe_pkg::CfgMinH:  min_h_q  <= cfg_wdata_i;
        hfe_pkg::CfgMaxW:  max_w_q  <= cfg_wdata_i;
        hfe_pkg::CfgMaxH:  max_h_q  <= cfg_wdata_i;
        hfe_pkg::CfgFamEn: fam_en_q <= cfg_wdata_i[2:0];
        default: ;
      endcase
    end
  end

  // Clamped and rounded limits, registered from the configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lim_q <= hfe_pkg::make_lim(hfe_pkg::WinWRst, hfe_pkg::WinHRst, hfe_pkg::MinWRst,
                                 hfe_pkg::MinHRst, hfe_pkg::MaxWRst, hfe_pkg::MaxHRst,
                                 hfe_pkg::FamEnRst);
    end else begin
      lim_q <= hfe_pkg::make_lim(win_w_q, win_h_q, min_w_q, min_h_q, max_w_q, max_h_q,
                                 fam_en_q);
    end
  end

  hfe_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_valid_i   (s_axis_tvalid_i),
    .req_restart_i (s_axis_tdata_i[0]),
    .req_ready_o   (s_axis_tready_o),
    .sts_i         (sts),
    .cmd_o         (cmd)
  );

  hfe_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .lim_i       (lim_q),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_data_o  (odata)
  );

  // Pack the result fields
  assign m_axis_tdata_o = {3'b000, odata.weight, odata.bottom, odata.right, odata.top,
                           odata.left, odata.family};
  assign m_axis_tlast_o = odata.last_rect;
  assign m_axis_tuser_o = odata.exhausted;

  // Checks
  `HFE_ASSERT_IMPLY(a_mark_last, m_axis_tvalid_o && m_axis_tuser_o,
                    m_axis_tlast_o, "exhausted marker without tlast")
  `HFE_ASSERT_IMPLY(a_mark_zero, m_axis_tvalid_o && m_axis_tuser_o,
                    m_axis_tdata_o == '0, "exhausted marker carries data")
  `HFE_ASSERT_NEXT(a_one_req, s_axis_tvalid_i && s_axis_tready_o,
                   !s_axis_tready_o, "second request taken while busy")
  `HFE_ASSERT_IMPLY(a_rect_weight, m_axis_tvalid_o && !m_axis_tuser_o,
                    m_axis_tdata_o[28:27] != 2'b00, "rectangle with zero weight")

endmodule
